### rtl/rgb_box_blur_window_average_macros.svh
// Assertion macros for the checker file of the box blur block.
`ifndef RGB_BOX_BLUR_WINDOW_AVERAGE_MACROS_SVH
`define RGB_BOX_BLUR_WINDOW_AVERAGE_MACROS_SVH

// Condition in this cycle implies consequence in the next cycle.
`define RBB_ASSERT_NEXT(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("next-cycle check failed");

// Condition in this cycle implies consequence in the same cycle.
`define RBB_ASSERT_NOW(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("same-cycle check failed");

`endif

### rtl/rbb_pkg.sv
// Types, constants and codes shared by the box blur block.
package rbb_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_WINDOW = 15;

  localparam int PIX_W   = 8;
  localparam int COORD_W = 8;
  localparam int DIM_W   = 9;
  localparam int WIN_W   = 4;
  localparam int XA_W    = $clog2(MAX_WIDTH);
  localparam int YA_W    = $clog2(MAX_HEIGHT);
  localparam int ADDR_W  = XA_W + YA_W;
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int SUM_W   = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
  localparam int CNT_W   = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int STEP_W  = $clog2(PIX_W);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd2;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [PIX_W-1:0]   red_in;
    logic [PIX_W-1:0]   green_in;
    logic [PIX_W-1:0]   blue_in;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_avg;
    logic [PIX_W-1:0] green_avg;
    logic [PIX_W-1:0] blue_avg;
    logic             position_error;
  } out_t;

endpackage

### rtl/rbb_div.sv
// Shared restoring divider: one quotient bit per cycle, eight-bit quotient.
module rbb_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rbb_pkg::SUM_W-1:0]  dividend,
  input  logic [rbb_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [rbb_pkg::PIX_W-1:0]  quotient
);
  import rbb_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  rem;
  logic [PIX_W-1:0]  low;
  logic [CNT_W-1:0]  dvs;
  logic [CNT_W:0]    trial;
  logic              fits;

  // Quotient is below 256, so the upper part of the dividend starts below the divisor.
  assign trial = {rem, low[PIX_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= !start && busy && (step == STEP_W'(PIX_W - 1));
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(PIX_W - 1))
          busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= CNT_W'(dividend >> PIX_W);
      low      <= dividend[PIX_W-1:0];
      dvs      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? CNT_W'(trial - {1'b0, dvs}) : trial[CNT_W-1:0];
      low      <= {low[PIX_W-2:0], 1'b0};
      quotient <= {quotient[PIX_W-2:0], fits};
    end
  end

endmodule

### rtl/rgb_box_blur_window_average.sv
// Top level of the RGB box blur: frame store, window sequencer and result register.
// Load beat: written into the frame store in its accept cycle; ready again next cycle.
// Compute beat: the clipped window is read one pixel per cycle from the frame store (9 pixels
// for a full 3x3 window, up to 225), and each channel sum then goes through the shared 8-step
// divider; an off-frame request skips both and goes straight to the result register.
// Reset (rst, synchronous) restores frame_width 256, frame_height 256, window_size 3; store kept.
module rgb_box_blur_window_average (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rbb_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rbb_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [rbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbb_pkg::DIM_W-1:0]     cfg_data
);
  import rbb_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_DSTART = 3'd3;
  localparam logic [2:0] S_DWAIT  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state;

  // Configuration registers, kept as written
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic [WIN_W-1:0] window_size;

  // Frame store: {red, green, blue} per pixel, row-major
  logic [3*PIX_W-1:0] mem [DEPTH];
  logic [3*PIX_W-1:0] rdata;
  logic               rd_pending;

  // Window walk
  logic [COORD_W-1:0] col0;
  logic [COORD_W-1:0] x;
  logic [COORD_W-1:0] y;
  logic [COORD_W-1:0] xlast;
  logic [COORD_W-1:0] ylast;

  // Accumulators and results
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_g;
  logic [SUM_W-1:0] sum_b;
  logic [CNT_W-1:0] count;
  logic [1:0]       ch;
  logic [PIX_W-1:0] avg_r;
  logic [PIX_W-1:0] avg_g;
  logic [PIX_W-1:0] avg_b;
  logic             err;

  // Clamped view of the registers and the clipped window for the beat on the input
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [WIN_W-1:0] k_eff;
  logic [DIM_W-1:0] xend;
  logic [DIM_W-1:0] yend;
  logic             off_frame;
  logic             accept;

  // Divider hookup
  logic             div_start;
  logic             div_done;
  logic [PIX_W-1:0] div_q;
  logic [SUM_W-1:0] div_dividend;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    if (frame_width == '0)
      w_eff = DIM_W'(1);
    else if (frame_width > DIM_W'(MAX_WIDTH))
      w_eff = DIM_W'(MAX_WIDTH);
    else
      w_eff = frame_width;

    if (frame_height == '0)
      h_eff = DIM_W'(1);
    else if (frame_height > DIM_W'(MAX_HEIGHT))
      h_eff = DIM_W'(MAX_HEIGHT);
    else
      h_eff = frame_height;

    if (window_size == '0)
      k_eff = WIN_W'(1);
    else if (window_size > WIN_W'(MAX_WINDOW))
      k_eff = WIN_W'(MAX_WINDOW);
    else
      k_eff = window_size;

    // Clip the window at the right and bottom frame edges
    xend = {1'b0, in_data.column} + {{(DIM_W-WIN_W){1'b0}}, k_eff};
    if (xend > w_eff)
      xend = w_eff;
    yend = {1'b0, in_data.row} + {{(DIM_W-WIN_W){1'b0}}, k_eff};
    if (yend > h_eff)
      yend = h_eff;

    off_frame = ({1'b0, in_data.column} >= w_eff) || ({1'b0, in_data.row} >= h_eff);
  end

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_W'(256);
      frame_height <= DIM_W'(256);
      window_size  <= WIN_W'(3);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        CFG_WINDOW_SIZE:  window_size  <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame store write port: loads land in their accept cycle
  always_ff @(posedge clk) begin
    if (accept && in_data.opcode == OP_LOAD)
      mem[{in_data.row[YA_W-1:0], in_data.column[XA_W-1:0]}] <=
        {in_data.red_in, in_data.green_in, in_data.blue_in};
  end

  // Frame store read port: registered, data in the cycle after the address
  always_ff @(posedge clk) begin
    rdata <= mem[{y[YA_W-1:0], x[XA_W-1:0]}];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
      ch         <= '0;
    end else begin
      rd_pending <= (state == S_READ);
      // Drop the result once the sink takes it, unless a new one replaces it
      if (out_valid && out_ready && state != S_FINISH)
        out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (accept && in_data.opcode == OP_COMPUTE) begin
            state <= off_frame ? S_FINISH : S_READ;
          end
        end
        S_READ: begin
          // Advance along the row, then wrap to the next row of the window
          if (x == xlast && y == ylast)
            state <= S_DRAIN;
        end
        S_DRAIN: begin
          // Last pixel is folded in at this edge
          state <= S_DSTART;
          ch    <= '0;
        end
        S_DSTART: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            if (ch == 2'd2) begin
              state <= S_FINISH;
            end else begin
              ch    <= ch + 1'b1;
              state <= S_DSTART;
            end
          end
        end
        S_FINISH: begin
          // Hold until the result register is free
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && in_data.opcode == OP_COMPUTE) begin
      col0  <= in_data.column;
      x     <= in_data.column;
      y     <= in_data.row;
      xlast <= COORD_W'(xend - 1'b1);
      ylast <= COORD_W'(yend - 1'b1);
      err   <= off_frame;
      sum_r <= '0;
      sum_g <= '0;
      sum_b <= '0;
      count <= '0;
      avg_r <= '0;
      avg_g <= '0;
      avg_b <= '0;
    end else begin
      if (state == S_READ) begin
        count <= count + 1'b1;
        if (x == xlast) begin
          x <= col0;
          if (y != ylast)
            y <= y + 1'b1;
        end else begin
          x <= x + 1'b1;
        end
      end
      if (rd_pending) begin
        sum_r <= sum_r + SUM_W'(rdata[3*PIX_W-1:2*PIX_W]);
        sum_g <= sum_g + SUM_W'(rdata[2*PIX_W-1:PIX_W]);
        sum_b <= sum_b + SUM_W'(rdata[PIX_W-1:0]);
      end
      if (state == S_DWAIT && div_done) begin
        case (ch)
          2'd0:    avg_r <= div_q;
          2'd1:    avg_g <= div_q;
          default: avg_b <= div_q;
        endcase
      end
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (state == S_FINISH && (!out_valid || out_ready)) begin
      out_data.red_avg        <= avg_r;
      out_data.green_avg      <= avg_g;
      out_data.blue_avg       <= avg_b;
      out_data.position_error <= err;
    end
  end

  always_comb begin
    case (ch)
      2'd0:    div_dividend = sum_r;
      2'd1:    div_dividend = sum_g;
      default: div_dividend = sum_b;
    endcase
  end

  assign div_start = (state == S_DSTART);

  rbb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule

### rtl/rbb_checker.sv
// Port-level checker for the box blur block, bound to the top level.
`include "rgb_box_blur_window_average_macros.svh"

module rbb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input rbb_pkg::in_t                  in_data,
  input logic                          out_valid,
  input logic                          out_ready,
  input rbb_pkg::out_t                 out_data
);
  import rbb_pkg::*;

  // A stalled result beat holds its payload
  `RBB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // A compute beat drops in_ready in the cycle after it is accepted
  `RBB_ASSERT_NEXT(a_compute_busy, in_valid && in_ready && in_data.opcode == OP_COMPUTE, !in_ready)

  // A load beat leaves the block ready for the next beat
  `RBB_ASSERT_NEXT(a_load_ready, in_valid && in_ready && in_data.opcode == OP_LOAD, in_ready)

  // An off-frame result carries zero averages
  `RBB_ASSERT_NOW(a_err_zero, out_valid && out_data.position_error,
    out_data.red_avg == '0 && out_data.green_avg == '0 && out_data.blue_avg == '0)

endmodule

bind rgb_box_blur_window_average rbb_checker u_rbb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### tb/sv/tb_rgb_box_blur_window_average.sv
// Self-checking testbench for the RGB box blur: frame loads, window averages, register settings.
module tb_rgb_box_blur_window_average;
  timeunit 1ns;
  timeprecision 1ps;

  import rbb_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_500_000;
  // Longest compute is a full 15 x 15 window of 225 pixels.
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned HOLD_AFTER    = 120;
  localparam int unsigned IDLE_PCT      = 37;
  localparam int unsigned PIX_BITS      = 3 * PIX_W;
  // Index past the last register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data  = '0;

  rgb_box_blur_window_average u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Register values as written; the block clamps them only when it uses them.
  logic [DIM_W-1:0] width_shadow  = DIM_W'(MAX_WIDTH);
  logic [DIM_W-1:0] height_shadow = DIM_W'(MAX_HEIGHT);
  logic [WIN_W-1:0] window_shadow = WIN_W'(3);

  // Mirror of the frame store as the accepted load beats leave it.
  logic [PIX_BITS-1:0] frame_mirror [DEPTH];
  // Pixels that some queued load beat will have written; computes read only these.
  bit                  pixel_loaded [DEPTH];

  in_t  pixel_requests    [$];
  out_t expected_averages [$];

  int unsigned in_beats         = 0;
  int unsigned mismatch_count   = 0;
  int unsigned cycle_count      = 0;
  int unsigned loads_queued     = 0;
  int unsigned computes_queued  = 0;
  int unsigned off_frame_queued = 0;
  int unsigned settings_used    = 0;
  int unsigned hold_left        = 0;
  bit          hold_done        = 1'b0;
  logic        request_taken    = 1'b0;

  // Both sides run without idling for a stretch of the input stream.
  wire steady_stretch = (in_beats >= 400) && (in_beats < 520);

  function automatic int unsigned clamp_dim(int unsigned value, int unsigned hi);
    if (value < 1) return 1;
    if (value > hi) return hi;
    return value;
  endfunction

  function automatic logic [ADDR_W-1:0] pixel_addr(int unsigned col, int unsigned row);
    return ADDR_W'(row * MAX_WIDTH + col);
  endfunction

  // Mean of each channel over the window clipped to the frame, or the off-frame flag.
  function automatic out_t predict_average(int unsigned col, int unsigned row);
    int unsigned w, h, k, x_end, y_end, count;
    int unsigned red_sum, green_sum, blue_sum;
    logic [PIX_BITS-1:0] pix;
    out_t avg;
    w = clamp_dim(32'(width_shadow), MAX_WIDTH);
    h = clamp_dim(32'(height_shadow), MAX_HEIGHT);
    k = clamp_dim(32'(window_shadow), MAX_WINDOW);
    avg = '0;
    if (col >= w || row >= h) begin
      avg.position_error = 1'b1;
      return avg;
    end
    x_end = (col + k > w) ? w : col + k;
    y_end = (row + k > h) ? h : row + k;
    red_sum = 0;
    green_sum = 0;
    blue_sum = 0;
    count = 0;
    for (int unsigned y = row; y < y_end; y++) begin
      for (int unsigned x = col; x < x_end; x++) begin
        pix = frame_mirror[pixel_addr(x, y)];
        red_sum += 32'(pix[3*PIX_W-1:2*PIX_W]);
        green_sum += 32'(pix[2*PIX_W-1:PIX_W]);
        blue_sum += 32'(pix[PIX_W-1:0]);
        count++;
      end
    end
    avg.red_avg = PIX_W'(red_sum / count);
    avg.green_avg = PIX_W'(green_sum / count);
    avg.blue_avg = PIX_W'(blue_sum / count);
    return avg;
  endfunction

  // Lean toward saturated and dark pixels so the sums reach their extremes.
  function automatic logic [PIX_BITS-1:0] pick_pixel();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15) return '1;
    if (roll < 25) return '0;
    return PIX_BITS'($urandom);
  endfunction

  function automatic void queue_load(int unsigned col, int unsigned row,
                                     logic [PIX_BITS-1:0] pix);
    in_t beat;
    beat.opcode = OP_LOAD;
    beat.column = COORD_W'(col);
    beat.row = COORD_W'(row);
    {beat.red_in, beat.green_in, beat.blue_in} = pix;
    pixel_requests.push_back(beat);
    pixel_loaded[pixel_addr(col, row)] = 1'b1;
    loads_queued++;
  endfunction

  // Load whatever part of the clipped window is still blank, then ask for the average.
  function automatic void queue_compute(int unsigned col, int unsigned row);
    int unsigned w, h, k;
    in_t beat;
    w = clamp_dim(32'(width_shadow), MAX_WIDTH);
    h = clamp_dim(32'(height_shadow), MAX_HEIGHT);
    k = clamp_dim(32'(window_shadow), MAX_WINDOW);
    if (col < w && row < h) begin
      for (int unsigned y = row; y < row + k && y < h; y++) begin
        for (int unsigned x = col; x < col + k && x < w; x++) begin
          if (!pixel_loaded[pixel_addr(x, y)]) queue_load(x, y, pick_pixel());
        end
      end
    end else begin
      off_frame_queued++;
    end
    beat.opcode = OP_COMPUTE;
    beat.column = COORD_W'(col);
    beat.row = COORD_W'(row);
    // Pixel fields are don't-care on a compute; fill them with noise.
    {beat.red_in, beat.green_in, beat.blue_in} = PIX_BITS'($urandom);
    pixel_requests.push_back(beat);
    computes_queued++;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      CFG_FRAME_WIDTH: begin
        width_shadow = value;
      end
      CFG_FRAME_HEIGHT: begin
        height_shadow = value;
      end
      CFG_WINDOW_SIZE: begin
        window_shadow = value[WIN_W-1:0];
      end
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                               logic [DIM_W-1:0] k);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_WINDOW_SIZE, k);
    settings_used++;
  endtask

  // Wait for every queued beat and every result, then let a trailing load settle.
  task automatic drain();
    while (pixel_requests.size() != 0 || in_valid || expected_averages.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Computes around a hot spot, so the preloaded windows get reused, mixed with stray loads
  // anywhere, requests past the frame edge and anchors anywhere in range.
  task automatic random_phase(int unsigned n_items, int unsigned roam_pct,
                              int unsigned spread);
    int unsigned first, w, h, base_col, base_row, roll;
    first = loads_queued + computes_queued;
    w = clamp_dim(32'(width_shadow), MAX_WIDTH);
    h = clamp_dim(32'(height_shadow), MAX_HEIGHT);
    base_col = $urandom_range(w - 1);
    base_row = $urandom_range(h - 1);
    while (loads_queued + computes_queued - first < n_items) begin
      roll = $urandom_range(99);
      if (roll < 20) begin
        queue_load($urandom_range(255), $urandom_range(255), pick_pixel());
      end else if (roll < 20 + roam_pct) begin
        queue_compute($urandom_range(255), $urandom_range(255));
      end else if (roll < 28 + roam_pct) begin
        if (w < MAX_WIDTH) queue_compute($urandom_range(255, w), $urandom_range(255));
        else if (h < MAX_HEIGHT) queue_compute($urandom_range(255), $urandom_range(255, h));
        else queue_compute($urandom_range(255), $urandom_range(255));
      end else begin
        queue_compute((base_col + $urandom_range(spread)) % w,
                      (base_row + $urandom_range(spread)) % h);
      end
    end
  endtask

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Driver: hold the beat until it is taken, then offer the next one or idle.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || request_taken) begin
      if (pixel_requests.size() != 0 && (steady_stretch || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_data <= pixel_requests.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off once traffic is flowing,
  // so results back up and the block has to stall its input.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && in_beats >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady_stretch || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Input side: apply each accepted beat to the mirror or predict its result.
  always @(posedge clk) begin
    if (rst) begin
      request_taken <= 1'b0;
    end else begin
      request_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        in_beats++;
        if (in_data.opcode == OP_LOAD)
          frame_mirror[pixel_addr(32'(in_data.column), 32'(in_data.row))] =
            {in_data.red_in, in_data.green_in, in_data.blue_in};
        else
          expected_averages.push_back(
            predict_average(32'(in_data.column), 32'(in_data.row)));
      end
    end
  end

  // Output side: compare each result beat with the oldest prediction.
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_averages.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        mismatch_count++;
      end else begin
        want = expected_averages.pop_front();
        check_field("red_avg", 32'(want.red_avg), 32'(out_data.red_avg));
        check_field("green_avg", 32'(want.green_avg), 32'(out_data.green_avg));
        check_field("blue_avg", 32'(want.blue_avg), 32'(out_data.blue_avg));
        check_field("position_error", 32'(want.position_error),
                    32'(out_data.position_error));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, expected_averages.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset setting: full 256 x 256 frame, 3 x 3 window. Hit the corner pixels and
    // the channel extremes, then windows clipped on the right and bottom edges.
    settings_used++;
    queue_load(0, 0, '1);
    queue_load(1, 0, '0);
    queue_load(255, 255, 24'hFF_00FF);
    queue_compute(0, 0);
    queue_compute(255, 255);
    queue_compute(254, 0);
    queue_compute(0, 254);
    drain();

    // Small frame with the largest window: off-frame requests on each axis,
    // a one-pixel corner window and a window clipped to the whole frame.
    apply_setting(9'd5, 9'd4, 9'd15);
    queue_compute(5, 0);
    queue_compute(0, 4);
    queue_compute(255, 255);
    queue_compute(4, 3);
    queue_compute(0, 0);
    drain();

    // Single-pixel frame with a zero window, which acts as one. An unused index
    // must leave everything as it was.
    apply_setting(9'd1, 9'd1, 9'd0);
    queue_compute(0, 0);
    queue_compute(1, 0);
    queue_compute(0, 1);
    drain();
    write_reg(CFG_UNUSED, 9'h1FF);
    queue_compute(0, 0);
    queue_compute(0, 1);
    drain();

    // Oversized width clamps to the maximum; small window, anchors anywhere.
    apply_setting(9'h1FF, 9'd256, 9'd2);
    random_phase(60, 30, 7);
    drain();

    // Narrow frame, largest window: nearly every window is clipped.
    apply_setting(9'd16, 9'd12, 9'd15);
    random_phase(200, 5, 4);
    drain();

    // Zero width acts as one column, oversized height clamps, the window field
    // keeps only its low bits.
    apply_setting(9'd0, 9'd300, 9'h1F6);
    random_phase(50, 10, 7);
    drain();

    // One-row frame.
    apply_setting(9'd256, 9'd1, 9'd15);
    random_phase(50, 15, 7);
    drain();

    // Mid-sized frame with tightly packed full 15 x 15 windows.
    apply_setting(9'd200, 9'd180, 9'd15);
    random_phase(280, 0, 1);
    drain();

    // Full frame with a one-pixel window.
    apply_setting(9'd256, 9'd256, 9'd1);
    random_phase(40, 30, 7);
    drain();

    $display("covered %0d pixel loads and %0d window requests (%0d off the frame)",
             loads_queued, computes_queued, off_frame_queued);
    $display("over %0d register settings, %0d mismatches", settings_used, mismatch_count);
    if (mismatch_count == 0 && expected_averages.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
